FILE: rtl/tcrp_pkg.sv
// ----------------------------------------------------------------------------
// tcrp_pkg
// Shared widths, command codes, register indexes and lane control type for
// the timed path playback block.
// ----------------------------------------------------------------------------
package tcrp_pkg;

	localparam int MAX_POINTS_DEF  = 256;
	localparam int COORD_WIDTH_DEF = 32;

	localparam int CMD_W   = 2;
	localparam int IO_W    = 32;  // coordinate and position port width
	localparam int DT_W    = 24;
	localparam int DUR_W   = 32;
	localparam int FRAC_W  = 16;  // fraction bits of alpha and t
	localparam int T_W     = FRAC_W + 1;
	localparam int APB_AW  = 3;
	localparam int LANES   = 3;

	localparam logic [T_W-1:0]   T_ONE        = T_W'(1) << FRAC_W;
	localparam logic [DUR_W-1:0] DUR_RST      = 32'd1000000;

	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_START = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

	localparam logic REG_CURVE_MODE = 1'b0;
	localparam logic REG_DEF_DUR    = 1'b1;

	typedef struct packed {
		logic           start;
		logic           mode;
		logic [T_W-1:0] t;
	} lane_ctl_t;

endpackage

FILE: rtl/tcrp_in_if.sv
// ----------------------------------------------------------------------------
// tcrp_in_if
// Command channel: valid/ready with one command item as payload.
// ----------------------------------------------------------------------------
interface tcrp_in_if;
	logic                              valid;
	logic                              ready;
	logic [tcrp_pkg::CMD_W-1:0]        cmd;
	logic signed [tcrp_pkg::IO_W-1:0]  coord_x;
	logic signed [tcrp_pkg::IO_W-1:0]  coord_y;
	logic signed [tcrp_pkg::IO_W-1:0]  coord_z;
	logic [tcrp_pkg::DT_W-1:0]         delta_time;
	logic [tcrp_pkg::DUR_W-1:0]        duration;
	logic                              notify_on_finish;

	modport source(output valid, cmd, coord_x, coord_y, coord_z, delta_time, duration,
		notify_on_finish, input ready);
	modport sink(input valid, cmd, coord_x, coord_y, coord_z, delta_time, duration,
		notify_on_finish, output ready);
endinterface

FILE: rtl/tcrp_out_if.sv
// ----------------------------------------------------------------------------
// tcrp_out_if
// Position channel: valid/ready with one position item as payload.
// ----------------------------------------------------------------------------
interface tcrp_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [tcrp_pkg::IO_W-1:0]  pos_x;
	logic signed [tcrp_pkg::IO_W-1:0]  pos_y;
	logic signed [tcrp_pkg::IO_W-1:0]  pos_z;
	logic                              finished;
	logic                              notify;

	modport source(output valid, pos_x, pos_y, pos_z, finished, notify, input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, finished, notify, output ready);
endinterface

FILE: rtl/tcrp_ram.sv
// ----------------------------------------------------------------------------
// tcrp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tcrp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/tcrp_div.sv
// ----------------------------------------------------------------------------
// tcrp_div
// Restoring divider for alpha: floor(dividend * 2^16 / divisor), one quotient
// bit per cycle. The dividend must be below the divisor.
// ----------------------------------------------------------------------------
module tcrp_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tcrp_pkg::DUR_W-1:0]    dividend,
	input  logic [tcrp_pkg::DUR_W-1:0]    divisor,
	output logic                          done,
	output logic [tcrp_pkg::FRAC_W-1:0]   quo
);

	localparam int CNT_W = $clog2(tcrp_pkg::FRAC_W + 1);

	logic [tcrp_pkg::DUR_W:0]     rem_q;
	logic [tcrp_pkg::DUR_W-1:0]   dvs_q;
	logic [tcrp_pkg::FRAC_W-1:0]  quo_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [tcrp_pkg::DUR_W:0]     shl;
	logic [tcrp_pkg::DUR_W:0]     sub;
	logic                         ge;

	// shift the remainder and trial subtract
	always_comb begin
		shl = {rem_q[tcrp_pkg::DUR_W-1:0], 1'b0};
		sub = shl - {1'b0, dvs_q};
		ge  = shl >= {1'b0, dvs_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(tcrp_pkg::FRAC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend};
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? sub : shl;
			quo_q <= {quo_q[tcrp_pkg::FRAC_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

FILE: rtl/tcrp_lane.sv
// ----------------------------------------------------------------------------
// tcrp_lane
// One coordinate lane: linear blend or uniform Catmull-Rom in Horner form,
// one shared multiplier by t, product registered before each add.
// ----------------------------------------------------------------------------
module tcrp_lane #(
	parameter int CW = tcrp_pkg::COORD_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tcrp_pkg::lane_ctl_t              ctl,
	input  logic signed [CW-1:0]             p0,
	input  logic signed [CW-1:0]             p1,
	input  logic signed [CW-1:0]             p2,
	input  logic signed [CW-1:0]             p3,
	output logic                             done,
	output logic signed [tcrp_pkg::IO_W-1:0] pos
);

	localparam int AW = CW + 6;
	localparam int PW = AW + tcrp_pkg::T_W + 1;
	localparam int SW = (AW > tcrp_pkg::IO_W + 1) ? AW : tcrp_pkg::IO_W + 1;
	localparam logic signed [PW-1:0] HALF = PW'(1) <<< (tcrp_pkg::FRAC_W - 1);
	localparam logic signed [SW-1:0] OMAX = SW'(64'sh7FFFFFFF);
	localparam logic signed [SW-1:0] OMIN = SW'(-64'sh80000000);

	logic signed [AW-1:0] e0, e1, e2, e3;
	logic signed [AW-1:0] c3, c2, c1, c0;
	logic signed [AW-1:0] acc_q;
	logic signed [AW-1:0] add_q [3];
	logic signed [PW-1:0] prod_q;
	logic signed [PW-1:0] rsum;
	logic signed [AW-1:0] rnd;
	logic signed [AW-1:0] half_v;
	logic signed [SW-1:0] fin_v;
	logic [1:0]           step_q;
	logic [1:0]           last_q;
	logic                 mode_q;
	logic                 busy_q;
	logic                 mul_q;
	logic                 fin_q;
	logic                 done_q;
	logic signed [tcrp_pkg::IO_W-1:0] pos_q;

	// curve coefficients
	always_comb begin
		e0 = AW'(p0);
		e1 = AW'(p1);
		e2 = AW'(p2);
		e3 = AW'(p3);
		c3 = e3 - e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2;
		c2 = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
		c1 = e2 - e0;
		c0 = e1 <<< 1;
	end

	// round product to nearest, ties up, and the final halving
	always_comb begin
		rsum   = prod_q + HALF;
		rnd    = AW'(rsum >>> tcrp_pkg::FRAC_W);
		half_v = (acc_q + AW'(1)) >>> 1;
		fin_v  = mode_q ? SW'(half_v) : SW'(acc_q);
	end

	// sequence: multiply, add, repeat until the last step, then finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mul_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				mul_q  <= 1'b1;
				fin_q  <= 1'b0;
			end else if (busy_q && mul_q) begin
				mul_q <= 1'b0;
			end else if (busy_q) begin
				if (step_q == last_q) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end else begin
					mul_q <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mode_q   <= ctl.mode;
			acc_q    <= ctl.mode ? c3 : e2 - e1;
			add_q[0] <= ctl.mode ? c2 : e1;
			add_q[1] <= c1;
			add_q[2] <= c0;
			step_q   <= '0;
			last_q   <= ctl.mode ? 2'd2 : 2'd0;
		end else if (busy_q && mul_q) begin
			prod_q <= PW'(acc_q) * PW'($signed({1'b0, ctl.t}));
		end else if (busy_q) begin
			acc_q  <= rnd + add_q[step_q];
			step_q <= step_q + 2'd1;
		end else if (fin_q) begin
			if (fin_v > OMAX) begin
				pos_q <= OMAX[tcrp_pkg::IO_W-1:0];
			end else if (fin_v < OMIN) begin
				pos_q <= OMIN[tcrp_pkg::IO_W-1:0];
			end else begin
				pos_q <= fin_v[tcrp_pkg::IO_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign pos  = pos_q;

endmodule

FILE: rtl/timed_catmull_rom_path_playback_top.sv
// ----------------------------------------------------------------------------
// timed_catmull_rom_path_playback_top
// Point store, playback timing and the three coordinate lanes, merged into
// one registered position result.
// ----------------------------------------------------------------------------
// Load and clear act on acceptance and leave the block idle. A start reads the
// points and runs the lanes; a tick first runs the bit-serial alpha divider, then
// scales and indexes. Both then do 4 point reads through the shared store read
// address and one or three multiply/add steps of the lane multiplier.
// One item at a time; the result register frees the input side while it waits.
// Reset (arst_n, asynchronous) empties the store count and stops playback.
module timed_catmull_rom_path_playback_top #(
	parameter int MAX_POINTS  = tcrp_pkg::MAX_POINTS_DEF,
	parameter int COORD_WIDTH = tcrp_pkg::COORD_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	tcrp_in_if.sink                     cmd_ch,
	tcrp_out_if.source                  pos_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tcrp_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int SC_W  = tcrp_pkg::T_W + CNT_W;
	localparam int DW    = tcrp_pkg::DUR_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_SCALE = 3'd2;
	localparam logic [2:0] ST_IDX   = 3'd3;
	localparam logic [2:0] ST_READ  = 3'd4;
	localparam logic [2:0] ST_RUN   = 3'd5;
	localparam logic [2:0] ST_HOLD  = 3'd6;

	logic [2:0]                 state_q;
	logic                       curve_mode_q;
	logic [DW-1:0]              def_dur_q;
	logic [CNT_W-1:0]           count_q;
	logic [DW-1:0]              elapsed_q;
	logic [DW-1:0]              active_q;
	logic                       playing_q;
	logic                       notify_en_q;
	logic                       ge_q;
	logic                       fin_q;
	logic [tcrp_pkg::T_W-1:0]   alpha_q;
	logic [SC_W-1:0]            scaled_q;
	logic [tcrp_pkg::T_W-1:0]   t_q;
	logic [IDX_W-1:0]           ptr_q [4];
	logic [2:0]                 rd_cnt_q;
	logic                       lane_go_q;
	logic                       out_valid_q;
	logic signed [31:0]         out_pos_q [tcrp_pkg::LANES];
	logic                       out_fin_q;
	logic                       out_ntf_q;

	logic                       in_acc;
	logic                       cfg_we;
	logic                       st_we;
	logic [DW:0]                e_sum;
	logic [DW-1:0]              e_sat;
	logic [DW-1:0]              dvs;
	logic                       div_start;
	logic                       div_done;
	logic [tcrp_pkg::FRAC_W-1:0] div_quo;
	logic                       out_free;
	logic [CNT_W:0]             seg;
	logic [CNT_W-1:0]           nm2;
	logic                       clamp;
	logic [CNT_W-1:0]           idx1;
	logic [CNT_W:0]             i3_try;
	logic [CNT_W-1:0]           i0, i2, i3;
	logic [1:0]                 cap;
	logic [IDX_W-1:0]           raddr;
	logic signed [31:0]         in_coord [tcrp_pkg::LANES];
	logic [COORD_WIDTH-1:0]     ld_coord [tcrp_pkg::LANES];
	logic [COORD_WIDTH-1:0]     rd_data [tcrp_pkg::LANES];
	logic signed [COORD_WIDTH-1:0] pt_q [tcrp_pkg::LANES][4];
	logic                       lane_done [tcrp_pkg::LANES];
	logic signed [31:0]         lane_pos [tcrp_pkg::LANES];
	tcrp_pkg::lane_ctl_t        lane_ctl;

	// handshakes
	assign cmd_ch.ready = (state_q == ST_IDLE);
	assign in_acc       = cmd_ch.valid && cmd_ch.ready;
	assign cfg_we       = psel && penable && pwrite;
	assign pready       = 1'b1;
	assign out_free     = !out_valid_q || pos_ch.ready;

	// register read back
	assign prdata = (paddr[2] == tcrp_pkg::REG_DEF_DUR) ? def_dur_q : {31'd0, curve_mode_q};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_mode_q <= 1'b0;
			def_dur_q    <= tcrp_pkg::DUR_RST;
		end else if (cfg_we) begin
			unique case (paddr[2])
				tcrp_pkg::REG_CURVE_MODE: curve_mode_q <= pwdata[0];
				tcrp_pkg::REG_DEF_DUR:    def_dur_q    <= pwdata;
				default: ;
			endcase
		end
	end

	// load coordinates, narrowed to a narrower store width with saturation, else sign-extended
	assign in_coord[0] = cmd_ch.coord_x;
	assign in_coord[1] = cmd_ch.coord_y;
	assign in_coord[2] = cmd_ch.coord_z;

	generate
		if (COORD_WIDTH >= 32) begin : g_ext
			for (genvar k = 0; k < tcrp_pkg::LANES; k++) begin : g_k
				assign ld_coord[k] = COORD_WIDTH'(in_coord[k]);
			end
		end else begin : g_sat
			localparam logic signed [31:0] CMAX = 32'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
			localparam logic signed [31:0] CMIN = ~CMAX;
			for (genvar k = 0; k < tcrp_pkg::LANES; k++) begin : g_k
				always_comb begin
					if (in_coord[k] > CMAX) begin
						ld_coord[k] = CMAX[COORD_WIDTH-1:0];
					end else if (in_coord[k] < CMIN) begin
						ld_coord[k] = CMIN[COORD_WIDTH-1:0];
					end else begin
						ld_coord[k] = in_coord[k][COORD_WIDTH-1:0];
					end
				end
			end
		end
	endgenerate

	assign st_we = in_acc && (cmd_ch.cmd == tcrp_pkg::CMD_LOAD) && !playing_q
		&& (count_q < CNT_W'(MAX_POINTS));

	// elapsed time, saturating, and the divisor
	always_comb begin
		e_sum     = {1'b0, elapsed_q} + (DW + 1)'(cmd_ch.delta_time);
		e_sat     = e_sum[DW] ? '1 : e_sum[DW-1:0];
		dvs       = (active_q == '0) ? DW'(1) : active_q;
		div_start = in_acc && (cmd_ch.cmd == tcrp_pkg::CMD_TICK) && playing_q
			&& (count_q >= CNT_W'(2));
	end

	tcrp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (e_sat),
		.divisor  (dvs),
		.done     (div_done),
		.quo      (div_quo)
	);

	// segment index, local t and the four neighbor indexes
	always_comb begin
		seg    = scaled_q[SC_W-1:tcrp_pkg::FRAC_W];
		nm2    = count_q - CNT_W'(2);
		clamp  = seg > {1'b0, nm2};
		idx1   = clamp ? nm2 : seg[CNT_W-1:0];
		i0     = (idx1 == '0) ? '0 : idx1 - CNT_W'(1);
		i2     = idx1 + CNT_W'(1);
		i3_try = {1'b0, idx1} + (CNT_W + 1)'(2);
		i3     = (i3_try < {1'b0, count_q}) ? i3_try[CNT_W-1:0] : count_q - CNT_W'(1);
		cap    = 2'(rd_cnt_q - 3'd1);
		raddr  = ptr_q[rd_cnt_q[1:0]];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			elapsed_q   <= '0;
			active_q    <= '0;
			playing_q   <= 1'b0;
			notify_en_q <= 1'b0;
			rd_cnt_q    <= '0;
			lane_go_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			lane_go_q <= 1'b0;
			if (pos_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (cmd_ch.cmd)
							tcrp_pkg::CMD_LOAD: begin
								if (st_we) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							tcrp_pkg::CMD_START: begin
								if (count_q >= CNT_W'(2)) begin
									elapsed_q   <= '0;
									active_q    <= (cmd_ch.duration == '0) ? def_dur_q
										: cmd_ch.duration;
									notify_en_q <= cmd_ch.notify_on_finish;
									playing_q   <= 1'b1;
									rd_cnt_q    <= '0;
									state_q     <= ST_READ;
								end
							end
							tcrp_pkg::CMD_TICK: begin
								if (div_start) begin
									elapsed_q <= e_sat;
									state_q   <= ST_DIV;
								end
							end
							default: begin
								count_q   <= '0;
								elapsed_q <= '0;
								active_q  <= '0;
								playing_q <= 1'b0;
							end
						endcase
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: state_q <= ST_IDX;
				ST_IDX: begin
					rd_cnt_q <= '0;
					state_q  <= ST_READ;
				end
				ST_READ: begin
					rd_cnt_q <= rd_cnt_q + 3'd1;
					if (rd_cnt_q == 3'd4) begin
						lane_go_q <= 1'b1;
						state_q   <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (lane_done[0]) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (fin_q) begin
							playing_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// timing and index datapath
	always_ff @(posedge clk) begin
		if (in_acc && (cmd_ch.cmd == tcrp_pkg::CMD_START)) begin
			fin_q <= 1'b0;
			t_q   <= '0;
			for (int k = 0; k < 4; k++) begin
				ptr_q[k] <= '0;
			end
		end
		if (div_start) begin
			ge_q  <= e_sat >= dvs;
			fin_q <= e_sat >= dvs;
		end
		if (div_done) begin
			alpha_q <= ge_q ? tcrp_pkg::T_ONE : {1'b0, div_quo};
		end
		if (state_q == ST_SCALE) begin
			scaled_q <= SC_W'(alpha_q) * SC_W'(count_q - CNT_W'(1));
		end
		if (state_q == ST_IDX) begin
			t_q      <= clamp ? tcrp_pkg::T_ONE : {1'b0, scaled_q[tcrp_pkg::FRAC_W-1:0]};
			ptr_q[0] <= IDX_W'(i0);
			ptr_q[1] <= IDX_W'(idx1);
			ptr_q[2] <= IDX_W'(i2);
			ptr_q[3] <= IDX_W'(i3);
		end
		if (state_q == ST_READ && rd_cnt_q != 3'd0) begin
			for (int l = 0; l < tcrp_pkg::LANES; l++) begin
				pt_q[l][cap] <= rd_data[l];
			end
		end
	end

	assign lane_ctl.start = lane_go_q;
	assign lane_ctl.mode  = curve_mode_q;
	assign lane_ctl.t     = t_q;

	// one store and one curve lane per coordinate
	generate
		for (genvar l = 0; l < tcrp_pkg::LANES; l++) begin : g_lane
			tcrp_ram #(
				.WIDTH (COORD_WIDTH),
				.DEPTH (MAX_POINTS)
			) u_store (
				.clk   (clk),
				.we    (st_we),
				.waddr (count_q[IDX_W-1:0]),
				.wdata (ld_coord[l]),
				.raddr (raddr),
				.rdata (rd_data[l])
			);

			tcrp_lane #(
				.CW (COORD_WIDTH)
			) u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (lane_ctl),
				.p0     (pt_q[l][0]),
				.p1     (pt_q[l][1]),
				.p2     (pt_q[l][2]),
				.p3     (pt_q[l][3]),
				.done   (lane_done[l]),
				.pos    (lane_pos[l])
			);
		end
	endgenerate

	// merge lanes into the result register
	always_ff @(posedge clk) begin
		if (state_q == ST_HOLD && out_free) begin
			for (int l = 0; l < tcrp_pkg::LANES; l++) begin
				out_pos_q[l] <= lane_pos[l];
			end
			out_fin_q <= fin_q;
			out_ntf_q <= fin_q && notify_en_q;
		end
	end

	assign pos_ch.valid    = out_valid_q;
	assign pos_ch.pos_x    = out_pos_q[0];
	assign pos_ch.pos_y    = out_pos_q[1];
	assign pos_ch.pos_z    = out_pos_q[2];
	assign pos_ch.finished = out_fin_q;
	assign pos_ch.notify   = out_ntf_q;

	// checks
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		st_we |-> !playing_q && state_q == ST_IDLE)
		else $error("store written during playback");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_POINTS))
		else $error("point count beyond capacity");

	a_lanes_sync: assert property (@(posedge clk) disable iff (!arst_n)
		lane_done[0] |-> lane_done[1] && lane_done[2] && state_q == ST_RUN)
		else $error("lanes out of step");

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside its state");

	a_fin_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HOLD && out_free && fin_q) |=> !playing_q && out_valid_q)
		else $error("playback not stopped on finish");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timed path playback block: a queue-fed command
// driver, a position monitor with an in-bench playback predictor, APB register
// phases between drained stretches of traffic, and random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int  LIMIT_CYCLES = 900000;
	localparam int  DRAIN_CYCLES = 64;
	localparam int  PHASE_ITEMS  = 85;
	localparam int  STORE_DEPTH  = tcrp_pkg::MAX_POINTS_DEF;
	localparam int  AW           = tcrp_pkg::APB_AW;
	localparam int  CW           = tcrp_pkg::CMD_W;
	localparam int  DTW          = tcrp_pkg::DT_W;
	localparam logic [AW-1:0] ADDR_CURVE = AW'(4 * tcrp_pkg::REG_CURVE_MODE);
	localparam logic [AW-1:0] ADDR_DUR   = AW'(4 * tcrp_pkg::REG_DEF_DUR);

	typedef struct {
		logic [CW-1:0]                   cmd;
		logic signed [tcrp_pkg::IO_W-1:0] x;
		logic signed [tcrp_pkg::IO_W-1:0] y;
		logic signed [tcrp_pkg::IO_W-1:0] z;
		logic [DTW-1:0]                  dt;
		logic [tcrp_pkg::DUR_W-1:0]      dur;
		logic                            nof;
	} cmd_item_t;

	typedef struct {
		logic [tcrp_pkg::IO_W-1:0] x;
		logic [tcrp_pkg::IO_W-1:0] y;
		logic [tcrp_pkg::IO_W-1:0] z;
		logic                      fin;
		logic                      ntf;
	} position_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [AW-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	tcrp_in_if  cin();
	tcrp_out_if cout();

	timed_catmull_rom_path_playback_top dut (
		.clk(clk), .arst_n(arst_n), .cmd_ch(cin), .pos_ch(cout),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	cmd_item_t pending_cmds[$];
	position_t expected_pos[$];
	int  errors;
	int  cycles;
	bit  quiet;
	int  in_gap;
	int  out_stall;

	// mirror of the playback state
	longint       path_x[STORE_DEPTH];
	longint       path_y[STORE_DEPTH];
	longint       path_z[STORE_DEPTH];
	int unsigned  path_len;
	bit [31:0]    play_elapsed;
	bit [31:0]    play_dur;
	bit           play_on;
	bit           play_notify;
	bit           mode_curve;
	bit [31:0]    dur_default;

	// round(c * t / 65536), ties up
	function automatic longint scale_t(longint c, longint t);
		longint hi;
		longint lo;
		hi = c >>> 16;
		lo = c & 64'hFFFF;
		return hi * t + ((lo * t + 32768) >>> 16);
	endfunction

	function automatic longint curve_point(longint p0, longint p1, longint p2, longint p3,
		longint t);
		longint v;
		if (!mode_curve)
			return p1 + scale_t(p2 - p1, t);
		v = scale_t(-p0 + 3 * p1 - 3 * p2 + p3, t) + (2 * p0 - 5 * p1 + 4 * p2 - p3);
		v = scale_t(v, t) + (p2 - p0);
		v = scale_t(v, t) + 2 * p1;
		return (v + 1) >>> 1;
	endfunction

	function automatic logic [31:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			v = 64'sd2147483647;
		if (v < -64'sd2147483648)
			v = -64'sd2147483648;
		return v[31:0];
	endfunction

	function automatic position_t path_position(int i0, int i1, int i2, int i3, longint t,
		bit fin);
		position_t p;
		p.x = clamp32(curve_point(path_x[i0], path_x[i1], path_x[i2], path_x[i3], t));
		p.y = clamp32(curve_point(path_y[i0], path_y[i1], path_y[i2], path_y[i3], t));
		p.z = clamp32(curve_point(path_z[i0], path_z[i1], path_z[i2], path_z[i3], t));
		p.fin = fin;
		p.ntf = fin && play_notify;
		return p;
	endfunction

	// advance the mirror by one accepted transaction, queue any position
	task automatic predict_path(cmd_item_t it);
		longint unsigned e, dv, alpha, scaled;
		int idx1, i0, i3, n;
		longint t;
		bit fin;
		case (it.cmd)
			tcrp_pkg::CMD_LOAD: begin
				if (!play_on && path_len < STORE_DEPTH) begin
					path_x[path_len] = longint'(it.x);
					path_y[path_len] = longint'(it.y);
					path_z[path_len] = longint'(it.z);
					path_len++;
				end
			end
			tcrp_pkg::CMD_START: begin
				if (path_len >= 2) begin
					play_elapsed = 0;
					play_dur = (it.dur != 0) ? it.dur : dur_default;
					play_notify = it.nof;
					play_on = 1;
					expected_pos.push_back(path_position(0, 0, 0, 0, 0, 0));
				end
			end
			tcrp_pkg::CMD_CLEAR: begin
				path_len = 0;
				play_elapsed = 0;
				play_dur = 0;
				play_on = 0;
			end
			default: begin
				if (play_on && path_len >= 2) begin
					e = longint'(play_elapsed) + longint'(it.dt);
					play_elapsed = (e > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
					dv = (play_dur != 0) ? play_dur : 1;
					if (longint'(play_elapsed) >= dv)
						alpha = 65536;
					else
						alpha = (longint'(play_elapsed) << 16) / dv;
					fin = alpha >= 65536;
					n = path_len;
					scaled = alpha * (n - 1);
					idx1 = int'(scaled >> 16);
					if (idx1 > n - 2)
						idx1 = n - 2;
					t = longint'(scaled) - (longint'(idx1) << 16);
					i0 = (idx1 != 0) ? idx1 - 1 : 0;
					i3 = (idx1 + 2 < n) ? idx1 + 2 : n - 1;
					expected_pos.push_back(path_position(i0, idx1, idx1 + 1, i3, t, fin));
					if (fin)
						play_on = 0;
				end
			end
		endcase
	endtask

	// clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// command driver with idle bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			cin.valid <= 0;
			in_gap <= 0;
		end else if (cin.valid && !cin.ready) begin
			// hold the current transaction
		end else if (in_gap > 0) begin
			cin.valid <= 0;
			in_gap <= in_gap - 1;
		end else if (pending_cmds.size() > 0) begin
			cmd_item_t it;
			it = pending_cmds.pop_front();
			cin.valid <= 1;
			cin.cmd <= it.cmd;
			cin.coord_x <= it.x;
			cin.coord_y <= it.y;
			cin.coord_z <= it.z;
			cin.delta_time <= it.dt;
			cin.duration <= it.dur;
			cin.notify_on_finish <= it.nof;
			if (!quiet && $urandom_range(0, 6) == 0)
				in_gap <= $urandom_range(1, 13);
		end else begin
			cin.valid <= 0;
		end
	end

	// position ready with stall bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			cout.ready <= 0;
			out_stall <= 0;
		end else if (out_stall > 0) begin
			cout.ready <= 0;
			out_stall <= out_stall - 1;
		end else begin
			cout.ready <= 1;
			if (!quiet && $urandom_range(0, 8) == 0)
				out_stall <= $urandom_range(1, 13);
		end
	end

	// monitor: check positions, predict accepted commands, watch the clock
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
		if (arst_n && cout.valid && cout.ready) begin
			if (expected_pos.size() == 0) begin
				$display("%0t: unexpected position x=%h y=%h z=%h", $time,
					cout.pos_x, cout.pos_y, cout.pos_z);
				errors++;
			end else begin
				position_t ex;
				ex = expected_pos.pop_front();
				if (ex.x !== cout.pos_x || ex.y !== cout.pos_y || ex.z !== cout.pos_z ||
					ex.fin !== cout.finished || ex.ntf !== cout.notify) begin
					$display("%0t: position mismatch exp x=%h y=%h z=%h fin=%b ntf=%b",
						$time, ex.x, ex.y, ex.z, ex.fin, ex.ntf);
					$display("%0t:                   got x=%h y=%h z=%h fin=%b ntf=%b",
						$time, cout.pos_x, cout.pos_y, cout.pos_z, cout.finished,
						cout.notify);
					errors++;
				end
			end
		end
		if (arst_n && cin.valid && cin.ready) begin
			cmd_item_t it;
			it.cmd = cin.cmd;
			it.x = cin.coord_x;
			it.y = cin.coord_y;
			it.z = cin.coord_z;
			it.dt = cin.delta_time;
			it.dur = cin.duration;
			it.nof = cin.notify_on_finish;
			predict_path(it);
		end
	end

	function automatic cmd_item_t mk(logic [CW-1:0] c, logic [31:0] x, logic [31:0] y,
		logic [31:0] z, logic [DTW-1:0] dt, logic [31:0] dur, logic nof);
		cmd_item_t it;
		it.cmd = c;
		it.x = x;
		it.y = y;
		it.z = z;
		it.dt = dt;
		it.dur = dur;
		it.nof = nof;
		return it;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom();
			default: return 32'($signed($urandom_range(0, 200000)) - 100000);
		endcase
	endfunction

	function automatic cmd_item_t rand_item();
		return mk(CW'($urandom_range(0, 3)), rand_coord(), rand_coord(), rand_coord(),
			DTW'($urandom()), $urandom(), 1'($urandom_range(0, 1)));
	endfunction

	task automatic apb_write(logic [AW-1:0] a, logic [31:0] d);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (a == ADDR_CURVE)
			mode_curve = d[0];
		else
			dur_default = d;
	endtask

	task automatic drain();
		while (pending_cmds.size() > 0 || cin.valid || expected_pos.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one path: optional clear, loads, start, ticks, with some noise
	task automatic queue_path(bit fill_store, ref int budget);
		int n, k;
		longint unsigned d;
		logic [31:0] dur;
		logic [DTW-1:0] dt;
		if ($urandom_range(0, 3) != 0) begin
			pending_cmds.push_back(mk(tcrp_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0));
			budget--;
		end
		if (fill_store)
			n = STORE_DEPTH + 4;
		else if ($urandom_range(0, 14) == 0)
			n = $urandom_range(0, 1);
		else
			n = $urandom_range(2, 9);
		for (k = 0; k < n; k++) begin
			pending_cmds.push_back(mk(tcrp_pkg::CMD_LOAD, rand_coord(), rand_coord(),
				rand_coord(), DTW'($urandom()), $urandom(), 1'($urandom_range(0, 1))));
			if (!fill_store)
				budget--;
		end
		case ($urandom_range(0, 7))
			0: dur = 0;
			1: dur = $urandom();
			2: dur = $urandom_range(1, 4);
			default: dur = $urandom_range(1, 300000);
		endcase
		pending_cmds.push_back(mk(tcrp_pkg::CMD_START, $urandom(), $urandom(), $urandom(),
			DTW'($urandom()), dur, 1'($urandom_range(0, 1))));
		budget--;
		d = (dur != 0) ? dur : dur_default;
		for (k = $urandom_range(1, 10); k > 0; k--) begin
			if ($urandom_range(0, 9) == 0) begin
				pending_cmds.push_back(rand_item());
			end else begin
				if ($urandom_range(0, 4) == 0)
					dt = DTW'($urandom());
				else
					dt = (d / $urandom_range(1, 6) > 64'hFF_FFFF) ? 24'hFF_FFFF :
						DTW'(d / $urandom_range(1, 6));
				pending_cmds.push_back(mk(tcrp_pkg::CMD_TICK, $urandom(), $urandom(),
					$urandom(), dt, $urandom(), 1'($urandom_range(0, 1))));
			end
			budget--;
		end
	endtask

	initial begin
		int ph, budget, k;
		errors = 0;
		cycles = 0;
		quiet = 0;
		cin.valid = 0;
		cin.cmd = tcrp_pkg::CMD_LOAD;
		cin.coord_x = 0;
		cin.coord_y = 0;
		cin.coord_z = 0;
		cin.delta_time = 0;
		cin.duration = 0;
		cin.notify_on_finish = 0;
		cout.ready = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		path_len = 0;
		play_elapsed = 0;
		play_dur = 0;
		play_on = 0;
		play_notify = 0;
		mode_curve = 0;
		dur_default = tcrp_pkg::DUR_RST;
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty starts, extremes, default duration, restart, overflow
		pending_cmds.push_back(mk(tcrp_pkg::CMD_START, 0, 0, 0, 0, 5, 1));
		pending_cmds.push_back(mk(tcrp_pkg::CMD_TICK, 0, 0, 0, 24'hFF_FFFF, 0, 0));
		pending_cmds.push_back(mk(tcrp_pkg::CMD_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0,
			0, 0));
		pending_cmds.push_back(mk(tcrp_pkg::CMD_START, 0, 0, 0, 0, 5, 1));
		pending_cmds.push_back(mk(tcrp_pkg::CMD_LOAD, 32'h8000_0000, 32'h7FFF_FFFF,
			32'hFFFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 1));
		pending_cmds.push_back(mk(tcrp_pkg::CMD_LOAD, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h0000_0100, 0, 0, 0));
		pending_cmds.push_back(mk(tcrp_pkg::CMD_START, 0, 0, 0, 0, 0, 1));
		pending_cmds.push_back(mk(tcrp_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0));
		pending_cmds.push_back(mk(tcrp_pkg::CMD_TICK, 0, 0, 0, 24'd333333, 0, 0));
		pending_cmds.push_back(mk(tcrp_pkg::CMD_TICK, 0, 0, 0, 24'hFF_FFFF, 0, 0));
		pending_cmds.push_back(mk(tcrp_pkg::CMD_TICK, 0, 0, 0, 24'd10, 0, 0));
		pending_cmds.push_back(mk(tcrp_pkg::CMD_START, 0, 0, 0, 0, 32'd100, 0));
		pending_cmds.push_back(mk(tcrp_pkg::CMD_LOAD, 32'h1234_5678, 32'h0, 32'h0, 0, 0, 0));
		pending_cmds.push_back(mk(tcrp_pkg::CMD_TICK, 0, 0, 0, 24'd50, 0, 0));
		pending_cmds.push_back(mk(tcrp_pkg::CMD_START, 0, 0, 0, 0, 32'hFFFF_FFFF, 1));
		for (k = 0; k < 4; k++)
			pending_cmds.push_back(mk(tcrp_pkg::CMD_TICK, 0, 0, 0, 24'hFF_FFFF, 0, 0));
		pending_cmds.push_back(mk(tcrp_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0));
		pending_cmds.push_back(mk(tcrp_pkg::CMD_TICK, 0, 0, 0, 24'd7, 0, 0));
		drain();

		// elapsed saturation: full-length duration run out by maximal ticks
		apb_write(ADDR_DUR, 32'hFFFF_FFFF);
		apb_write(ADDR_CURVE, 1);
		pending_cmds.push_back(mk(tcrp_pkg::CMD_LOAD, 32'h100, 32'h200, 32'h300, 0, 0, 0));
		pending_cmds.push_back(mk(tcrp_pkg::CMD_LOAD, 32'hFFFF_FF00, 32'h0, 32'h7FFF_FFFF,
			0, 0, 0));
		pending_cmds.push_back(mk(tcrp_pkg::CMD_START, 0, 0, 0, 0, 0, 1));
		for (k = 0; k < 257; k++)
			pending_cmds.push_back(mk(tcrp_pkg::CMD_TICK, 0, 0, 0, 24'hFF_FFFF, 0, 0));
		drain();

		// random phases across register settings, last one without idling
		for (ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin apb_write(ADDR_CURVE, 0); apb_write(ADDR_DUR, 1); end
				1: begin apb_write(ADDR_CURVE, 1); apb_write(ADDR_DUR, tcrp_pkg::DUR_RST); end
				2: begin apb_write(ADDR_CURVE, 0); apb_write(ADDR_DUR, $urandom()); end
				3: begin apb_write(ADDR_CURVE, 1); apb_write(ADDR_DUR, 1); end
				4: begin
					apb_write(ADDR_CURVE, 1);
					apb_write(ADDR_DUR, $urandom_range(1, 500000));
				end
				default: begin
					apb_write(ADDR_CURVE, 0);
					apb_write(ADDR_DUR, 32'hFFFF_FFFF);
					quiet = 1;
				end
			endcase
			budget = PHASE_ITEMS;
			while (budget > 0)
				queue_path((ph == 1 || ph == 4) && budget == PHASE_ITEMS, budget);
			drain();
		end

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: timed_catmull_rom_path_playback_top.f
rtl/tcrp_pkg.sv
rtl/tcrp_in_if.sv
rtl/tcrp_out_if.sv
rtl/tcrp_ram.sv
rtl/tcrp_div.sv
rtl/tcrp_lane.sv
rtl/timed_catmull_rom_path_playback_top.sv
dv/tb_top.sv
